// File: rtl/core/kwnw_pkg.sv
package kwnw_pkg;

  // search geometry
  localparam int MAX_KEY_BYTES = 16;
  localparam int OFFSET_BITS   = 32;
  localparam int HIST_DEPTH    = 2 * MAX_KEY_BYTES - 1;
  localparam int NPOS          = HIST_DEPTH + 1;
  localparam int LEN_W         = $clog2(MAX_KEY_BYTES + 1);
  localparam int KIDX_W        = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  // fixed field widths
  localparam int CFG_W        = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int KEY_LEN_W    = 5;
  localparam int START_W      = 32;
  localparam logic [7:0] WIDE_PAD = 8'h00;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LOW  = 2'd0,
    REG_KEY_HIGH = 2'd1,
    REG_KEY_LEN  = 2'd2
  } cfg_reg_e;

  // what one window position is compared against
  typedef struct packed {
    logic [7:0] exp_n;
    logic [7:0] exp_w;
    logic       use_n;
    logic       use_w;
  } cell_pat_t;

  // compare result of one window position
  typedef struct packed {
    logic n_ok;
    logic w_ok;
  } cell_match_t;

  function automatic cell_match_t cell_cmp(logic [7:0] b, cell_pat_t p);
    cell_match_t m;
    m.n_ok = !p.use_n || (b == p.exp_n);
    m.w_ok = !p.use_w || (b == p.exp_w);
    return m;
  endfunction

  // clamp a written key length into 1..MAX_KEY_BYTES
  function automatic logic [LEN_W-1:0] clamp_len(logic [KEY_LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (int'(v) > MAX_KEY_BYTES) begin
      r = LEN_W'(MAX_KEY_BYTES);
    end else begin
      r = LEN_W'(v);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/kwnw_pattern.sv
module kwnw_pattern
  import kwnw_pkg::*;
(
  input  logic [CFG_W-1:0] key_low_i,
  input  logic [CFG_W-1:0] key_high_i,
  input  logic [LEN_W-1:0] len_i,
  output cell_pat_t        pat_o [NPOS]
);

  logic [7:0] key_arr [MAX_KEY_BYTES];

  // keyword bytes, positions past the two registers read as zero
  always_comb begin
    for (int j = 0; j < MAX_KEY_BYTES; j++) begin
      if (j < 8) begin
        key_arr[j] = key_low_i[8*j +: 8];
      end else if (j < 16) begin
        key_arr[j] = key_high_i[8*(j-8) +: 8];
      end else begin
        key_arr[j] = 8'h00;
      end
    end
  end

  // expected byte for each distance back from the newest byte
  always_comb begin
    int nj;
    int wj;
    for (int k = 0; k < NPOS; k++) begin
      nj = int'(len_i) - 1 - k;
      wj = 2 * int'(len_i) - 1 - k;
      pat_o[k].use_n = (k < int'(len_i));
      pat_o[k].use_w = (k < 2 * int'(len_i));
      pat_o[k].exp_n = pat_o[k].use_n ? key_arr[KIDX_W'(nj)] : 8'h00;
      if (pat_o[k].use_w && !wj[0]) begin
        pat_o[k].exp_w = key_arr[KIDX_W'(wj >> 1)];
      end else begin
        pat_o[k].exp_w = WIDE_PAD;
      end
    end
  end

endmodule

// File: rtl/core/kwnw_cell.sv
module kwnw_cell
  import kwnw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        shift_i,
  input  logic        clear_i,
  input  logic [7:0]  byte_i,
  input  cell_pat_t   pat_i,
  output logic [7:0]  byte_o,
  output cell_match_t match_o
);

  logic [7:0] byte_q;

  // one history byte, moves one place older per beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else if (clear_i) begin
      byte_q <= 8'h00;
    end else if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o  = byte_q;
  assign match_o = cell_cmp(byte_q, pat_i);

endmodule

// File: rtl/core/keyword_search_narrow_wide.sv
// channel | direction | handshake                | payload
// --------+-----------+--------------------------+-------------------------------------------
// in      | input     | in_valid_i / in_ready_o   | data_byte_i, last_byte_i
// out     | output    | out_valid_o / out_ready_i | narrow_hit/start, wide_hit/start, any_found,
//         |           |                          | region_end
// cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// one byte per cycle unless the output stalls; each result appears the cycle after acceptance.
// the window compare is a row of byte cells shifted each beat, all compared at once.
// the output register holds a result while out_ready_i is low; a new byte is taken
// in the same cycle the held result leaves.
// reset clears history, offset, found flag and key registers (key length resets to 1).
module keyword_search_narrow_wide
  import kwnw_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 narrow_hit_o,
  output logic [START_W-1:0]   narrow_start_o,
  output logic                 wide_hit_o,
  output logic [START_W-1:0]   wide_start_o,
  output logic                 any_found_o,
  output logic                 region_end_o
);

  logic [CFG_W-1:0]     key_low_q;
  logic [CFG_W-1:0]     key_high_q;
  logic [KEY_LEN_W-1:0] key_len_q;
  logic [LEN_W-1:0]     len;

  logic [OFFSET_BITS-1:0] pos_q;
  logic                   found_q;

  cell_pat_t   pat   [NPOS];
  cell_match_t match [NPOS];
  logic [7:0]  hist  [NPOS];

  logic accept;
  logic shift;
  logic clear;
  logic n_all;
  logic w_all;
  logic n_hit;
  logic w_hit;
  logic any;
  logic [OFFSET_BITS-1:0] n_start;
  logic [OFFSET_BITS-1:0] w_start;

  logic               out_valid_q;
  logic               n_hit_q;
  logic [START_W-1:0] n_start_q;
  logic               w_hit_q;
  logic [START_W-1:0] w_start_q;
  logic               any_q;
  logic               end_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      key_len_q  <= KEY_LEN_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_KEY_LOW:  key_low_q  <= cfg_data_i;
        REG_KEY_HIGH: key_high_q <= cfg_data_i;
        REG_KEY_LEN:  key_len_q  <= cfg_data_i[KEY_LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  assign len = clamp_len(key_len_q);

  kwnw_pattern u_pattern (
    .key_low_i  (key_low_q),
    .key_high_i (key_high_q),
    .len_i      (len),
    .pat_o      (pat)
  );

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign shift      = accept && !last_byte_i;
  assign clear      = accept && last_byte_i;

  // newest byte compared directly, older bytes held in the cell row
  assign hist[0]  = data_byte_i;
  assign match[0] = cell_cmp(data_byte_i, pat[0]);

  for (genvar k = 1; k < NPOS; k++) begin : g_cell
    kwnw_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift),
      .clear_i (clear),
      .byte_i  (hist[k-1]),
      .pat_i   (pat[k]),
      .byte_o  (hist[k]),
      .match_o (match[k])
    );
  end

  // reduce per-position compares
  always_comb begin
    n_all = 1'b1;
    w_all = 1'b1;
    for (int k = 0; k < NPOS; k++) begin
      n_all = n_all && match[k].n_ok;
      w_all = w_all && match[k].w_ok;
    end
  end

  // match must lie fully inside the region
  assign n_hit   = n_all && (pos_q >= OFFSET_BITS'(len - LEN_W'(1)));
  assign w_hit   = w_all && ({1'b0, pos_q} >=
                   (OFFSET_BITS + 1)'({len, 1'b0} - (LEN_W + 1)'(1)));
  assign n_start = pos_q - OFFSET_BITS'(len - LEN_W'(1));
  assign w_start = pos_q - OFFSET_BITS'({len, 1'b0} - (LEN_W + 1)'(1));
  assign any     = found_q || n_hit || w_hit;

  // region offset and sticky flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      found_q <= 1'b0;
    end else if (clear) begin
      pos_q   <= '0;
      found_q <= 1'b0;
    end else if (shift) begin
      found_q <= any;
      if (pos_q != '1) begin
        pos_q <= pos_q + OFFSET_BITS'(1);
      end
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      n_hit_q   <= n_hit;
      n_start_q <= n_hit ? START_W'(n_start) : '0;
      w_hit_q   <= w_hit;
      w_start_q <= w_hit ? START_W'(w_start) : '0;
      any_q     <= any;
      end_q     <= last_byte_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign narrow_hit_o   = n_hit_q;
  assign narrow_start_o = n_start_q;
  assign wide_hit_o     = w_hit_q;
  assign wide_start_o   = w_start_q;
  assign any_found_o    = any_q;
  assign region_end_o   = end_q;

endmodule
